FILE: rtl/blpa_pkg.sv
// Shared types, constants and helpers for the linked block pool allocator.
// No dependencies; every other file uses it by scoped names.
package blpa_pkg;

    localparam int POOL_CAPACITY = 4096;
    localparam int INIT_DEFAULT  = 1024;
    localparam int INIT_MAX      = 4096;
    localparam int INIT_LIMIT    = (INIT_MAX < POOL_CAPACITY) ? INIT_MAX : POOL_CAPACITY;

    localparam int IDX_W = $clog2(POOL_CAPACITY);
    localparam int CNT_W = IDX_W + 1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // block pointer: valid bit plus index, all zero is null
    typedef struct packed {
        logic valid;
        t_idx idx;
    } t_ptr;

    // request codes on the input channel
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_LINK   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ALLOC,
        OP_FREE,
        OP_LINK
    } t_op;

    typedef struct packed {
        t_op  op;
        t_cnt cnt;
        t_ptr p1;
        t_ptr p2;
    } t_cmd;

    // queue head toward the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q2b;

    // back end status toward the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_b2f;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK_RD,
        S_WALK_STEP,
        S_MINT,
        S_TERM,
        S_APPEND,
        S_DONE
    } t_state;

    // pool size from the register value: zero picks the default, clamp the rest
    function automatic t_cnt f_init_size(input t_cnt v);
        t_cnt n;
        if (v == '0) begin
            n = CNT_W'(INIT_DEFAULT);
        end else if (int'(v) > INIT_LIMIT) begin
            n = CNT_W'(INIT_LIMIT);
        end else begin
            n = v;
        end
        return n;
    endfunction

endpackage

FILE: rtl/blpa_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on blpa_pkg for field widths.
interface blpa_req_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    blpa_pkg::t_cnt        block_count;
    blpa_pkg::t_idx        first_block;
    logic                  first_valid;
    blpa_pkg::t_idx        second_block;
    logic                  second_valid;

    modport source (output valid, action, block_count, first_block, first_valid,
                    second_block, second_valid, input ready);
    modport sink   (input valid, action, block_count, first_block, first_valid,
                    second_block, second_valid, output ready);
endinterface

interface blpa_rsp_if;
    logic                  valid;
    logic                  ready;
    logic                  status;
    blpa_pkg::t_idx        chain_head;
    blpa_pkg::t_idx        chain_tail;
    logic                  chain_valid;
    blpa_pkg::t_cnt        pool_blocks;
    blpa_pkg::t_cnt        free_blocks;

    modport source (output valid, status, chain_head, chain_tail, chain_valid,
                    pool_blocks, free_blocks, input ready);
    modport sink   (input valid, status, chain_head, chain_tail, chain_valid,
                    pool_blocks, free_blocks, output ready);
endinterface

FILE: rtl/linked_block_pool_allocator_top.sv
// Top level of the linked block pool allocator: front end, command queue and
// back end. Depends on blpa_pkg, blpa_if, blpa_front and blpa_back.
//
// Requests enter a two-entry queue and are carried out one at a time by a
// sequencer around a next-pointer memory with one write port and one
// registered read. Free, link and no-op requests go through the execute and
// done states; an allocation walks blocks off the free list (a read and a
// step state per block), mints fresh blocks one at a time, nulls the chain
// tail and, if it fails, returns its blocks in an append state. After reset
// and after every write of the initial-size register a clearing pass rewrites
// every memory entry, during which no request beat is accepted. A finished
// result waits in an output register while the next request is accepted into the queue.
module linked_block_pool_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blpa_req_if.sink    i_req,
    blpa_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    blpa_pkg::t_q2b q2b;
    blpa_pkg::t_b2f b2f;

    // accept and classify
    blpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_b2f   (b2f),
        .o_q2b   (q2b)
    );

    // execute against the pool
    blpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q2b   (q2b),
        .o_b2f   (b2f),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

endmodule

FILE: rtl/blpa_front.sv
// Front end: accept request beats, classify them into commands, hold them
// in a two-entry queue for the back end. Depends on blpa_pkg and blpa_if.
module blpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    blpa_req_if.sink          i_req,
    input  blpa_pkg::t_b2f    i_b2f,
    output blpa_pkg::t_q2b    o_q2b
);

    blpa_pkg::t_cmd r_q [2];
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;
    blpa_pkg::t_cmd cmd;
    logic           push;

    // classify the request; requests that change nothing become no-ops
    always_comb begin
        cmd.cnt = i_req.block_count;
        cmd.p1  = '{valid: i_req.first_valid,  idx: i_req.first_block};
        cmd.p2  = '{valid: i_req.second_valid, idx: i_req.second_block};
        if (!i_req.first_valid)  cmd.p1 = '0;
        if (!i_req.second_valid) cmd.p2 = '0;
        unique case (i_req.action)
            blpa_pkg::ACT_ALLOC:
                cmd.op = (i_req.block_count != '0) ? blpa_pkg::OP_ALLOC : blpa_pkg::OP_NOP;
            blpa_pkg::ACT_FREE:
                cmd.op = (i_req.block_count != '0 && i_req.first_valid && i_req.second_valid)
                         ? blpa_pkg::OP_FREE : blpa_pkg::OP_NOP;
            blpa_pkg::ACT_LINK:
                cmd.op = i_req.first_valid ? blpa_pkg::OP_LINK : blpa_pkg::OP_NOP;
            default:
                cmd.op = blpa_pkg::OP_NOP;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2) && !i_b2f.clearing;
    assign push        = i_req.valid && i_req.ready;

    // advance pointers and fill level
    always_comb begin
        n_wp  = r_wp ^ push;
        n_rp  = r_rp ^ i_b2f.pop;
        n_cnt = r_cnt + 2'(push) - 2'(i_b2f.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // store the command
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    assign o_q2b.valid = (r_cnt != 2'd0);
    assign o_q2b.cmd   = r_q[r_rp];

endmodule

FILE: rtl/blpa_back.sv
// Back end: next-pointer memory, free list registers, the command sequencer,
// the clearing pass, the config register and the result register.
// Depends on blpa_pkg and blpa_if.
module blpa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blpa_pkg::t_q2b    i_q2b,
    output blpa_pkg::t_b2f    o_b2f,
    blpa_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam blpa_pkg::t_cnt RST_SIZE = blpa_pkg::f_init_size('0);
    localparam blpa_pkg::t_idx LAST_IDX = blpa_pkg::IDX_W'(blpa_pkg::POOL_CAPACITY - 1);

    blpa_pkg::t_state r_state, n_state;
    blpa_pkg::t_ptr   r_head, n_head, r_tail, n_tail;
    blpa_pkg::t_cnt   r_fcnt, n_fcnt, r_mint, n_mint;
    blpa_pkg::t_cnt   r_init, n_init, r_n, n_n;
    blpa_pkg::t_idx   r_clr, n_clr;
    logic             r_ovalid, n_ovalid;

    blpa_pkg::t_cmd   r_cmd, n_cmd;
    blpa_pkg::t_cnt   r_got, n_got;
    blpa_pkg::t_idx   r_ch, n_ch, r_ct, n_ct;
    blpa_pkg::t_ptr   r_cur, n_cur, r_rd;
    logic             r_term, n_term, r_status, n_status, r_chok, n_chok;
    logic             r_ostat, n_ostat, r_ochok, n_ochok;
    blpa_pkg::t_idx   r_ohead, n_ohead, r_otail, n_otail;
    blpa_pkg::t_cnt   r_otot, n_otot, r_ofree, n_ofree;

    blpa_pkg::t_ptr   mem [blpa_pkg::POOL_CAPACITY];
    logic             we;
    blpa_pkg::t_idx   wa;
    blpa_pkg::t_ptr   wd;

    logic             cfg_wr;
    blpa_pkg::t_cnt   cfg_n;
    logic             do_append;
    blpa_pkg::t_ptr   app_h, app_t;
    blpa_pkg::t_cnt   app_c;
    logic [blpa_pkg::CNT_W:0] app_sum;
    logic             mint_go;
    logic             out_free;

    // config port: one register, aliased at addresses 0 to 3, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign cfg_n  = blpa_pkg::f_init_size(pwdata[blpa_pkg::CNT_W-1:0]);
    assign prdata = paddr[2] ? 32'd0 : 32'(r_init);

    assign mint_go  = (r_got < r_cmd.cnt) && (int'(r_mint) < blpa_pkg::POOL_CAPACITY);
    assign out_free = !r_ovalid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            blpa_pkg::S_CLEAR:     if (r_clr == LAST_IDX) n_state = blpa_pkg::S_IDLE;
            blpa_pkg::S_IDLE:      if (i_q2b.valid) n_state = blpa_pkg::S_EXEC;
            blpa_pkg::S_EXEC: begin
                if (r_cmd.op == blpa_pkg::OP_ALLOC) begin
                    n_state = (r_fcnt != '0 && r_cmd.cnt < r_fcnt)
                              ? blpa_pkg::S_WALK_RD : blpa_pkg::S_MINT;
                end else begin
                    n_state = blpa_pkg::S_DONE;
                end
            end
            blpa_pkg::S_WALK_RD:
                n_state = r_cur.valid ? blpa_pkg::S_WALK_STEP : blpa_pkg::S_MINT;
            blpa_pkg::S_WALK_STEP:
                n_state = (r_got == r_cmd.cnt) ? blpa_pkg::S_MINT : blpa_pkg::S_WALK_RD;
            blpa_pkg::S_MINT:      if (!mint_go) n_state = blpa_pkg::S_TERM;
            blpa_pkg::S_TERM:
                n_state = (r_got < r_cmd.cnt && r_got != '0)
                          ? blpa_pkg::S_APPEND : blpa_pkg::S_DONE;
            blpa_pkg::S_APPEND:    n_state = blpa_pkg::S_DONE;
            blpa_pkg::S_DONE:      if (out_free) n_state = blpa_pkg::S_IDLE;
            default:               n_state = blpa_pkg::S_IDLE;
        endcase
        if (cfg_wr) n_state = blpa_pkg::S_CLEAR;
    end

    // datapath and memory write port
    always_comb begin
        n_head = r_head;  n_tail = r_tail;  n_fcnt = r_fcnt;  n_mint = r_mint;
        n_init = r_init;  n_n = r_n;        n_clr = r_clr;
        n_cmd = r_cmd;    n_got = r_got;    n_ch = r_ch;      n_ct = r_ct;
        n_cur = r_cur;    n_term = r_term;  n_status = r_status; n_chok = r_chok;
        n_ostat = r_ostat; n_ochok = r_ochok; n_ohead = r_ohead; n_otail = r_otail;
        n_otot = r_otot;  n_ofree = r_ofree;
        n_ovalid = r_ovalid && !o_rsp.ready;
        we = 1'b0;  wa = '0;  wd = '0;
        do_append = 1'b0;
        o_b2f.pop = 1'b0;
        o_b2f.clearing = (r_state == blpa_pkg::S_CLEAR);

        unique case (r_state)
            blpa_pkg::S_CLEAR: begin
                // write the initial chain one entry a cycle
                we = 1'b1;
                wa = r_clr;
                if (blpa_pkg::CNT_W'(r_clr) + 1'b1 < r_n) begin
                    wd = '{valid: 1'b1, idx: r_clr + 1'b1};
                end
                n_clr = r_clr + 1'b1;
            end
            blpa_pkg::S_IDLE: begin
                if (i_q2b.valid) begin
                    o_b2f.pop = 1'b1;
                    n_cmd = i_q2b.cmd;
                    n_got = '0;  n_ch = '0;  n_ct = '0;
                    n_term = 1'b0;  n_status = 1'b0;  n_chok = 1'b0;
                end
            end
            blpa_pkg::S_EXEC: begin
                case (r_cmd.op)
                    blpa_pkg::OP_LINK: begin
                        we = 1'b1;  wa = r_cmd.p1.idx;  wd = r_cmd.p2;
                    end
                    blpa_pkg::OP_FREE: do_append = 1'b1;
                    blpa_pkg::OP_ALLOC: begin
                        if (r_fcnt != '0) begin
                            if (r_cmd.cnt >= r_fcnt) begin
                                // take the whole list
                                if (r_head.valid && r_tail.valid) begin
                                    n_ch = r_head.idx;  n_ct = r_tail.idx;  n_got = r_fcnt;
                                end
                                n_head = '0;  n_tail = '0;  n_fcnt = '0;
                            end else begin
                                n_cur = r_head;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            blpa_pkg::S_WALK_RD: begin
                if (!r_cur.valid) begin
                    // broken list: keep what was walked, drop the rest
                    n_head = '0;  n_tail = '0;  n_fcnt = '0;
                    n_term = (r_got != '0);
                end else begin
                    if (r_got == '0) n_ch = r_cur.idx;
                    n_ct  = r_cur.idx;
                    n_got = r_got + 1'b1;
                end
            end
            blpa_pkg::S_WALK_STEP: begin
                n_cur = r_rd;
                if (r_got == r_cmd.cnt) begin
                    n_head = r_rd.valid ? r_rd : '0;
                    n_fcnt = r_fcnt - r_got;
                    n_term = 1'b1;
                end
            end
            blpa_pkg::S_MINT: begin
                // mint one fresh block and hook it behind the chain tail, or start the chain with it
                if (mint_go) begin
                    if (r_got == '0) begin
                        n_ch = r_mint[blpa_pkg::IDX_W-1:0];
                    end else begin
                        we = 1'b1;  wa = r_ct;
                        wd = '{valid: 1'b1, idx: r_mint[blpa_pkg::IDX_W-1:0]};
                    end
                    n_ct   = r_mint[blpa_pkg::IDX_W-1:0];
                    n_mint = r_mint + 1'b1;
                    n_got  = r_got + 1'b1;
                    n_term = 1'b1;
                end
            end
            blpa_pkg::S_TERM: begin
                // null the chain tail's next pointer
                if (r_term) begin
                    we = 1'b1;  wa = r_ct;  wd = '0;
                end
                if (r_got < r_cmd.cnt) n_status = 1'b1;
                else                   n_chok   = 1'b1;
            end
            blpa_pkg::S_APPEND: do_append = 1'b1;
            blpa_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_status;
                    n_ochok  = r_chok;
                    n_ohead  = r_chok ? r_ch : '0;
                    n_otail  = r_chok ? r_ct : '0;
                    n_otot   = r_mint;
                    n_ofree  = r_fcnt;
                end
            end
            default: ;
        endcase

        // append a chain to the free list, saturating the count
        if (r_state == blpa_pkg::S_APPEND) begin
            app_h = '{valid: 1'b1, idx: r_ch};
            app_t = '{valid: 1'b1, idx: r_ct};
            app_c = r_got;
        end else begin
            app_h = r_cmd.p1;
            app_t = r_cmd.p2;
            app_c = r_cmd.cnt;
        end
        app_sum = {1'b0, r_fcnt} + {1'b0, app_c};
        if (do_append && app_c != '0 && app_h.valid && app_t.valid) begin
            if (!r_head.valid || !r_tail.valid) begin
                n_head = app_h;
            end else begin
                we = 1'b1;  wa = r_tail.idx;  wd = app_h;
            end
            n_tail = app_t;
            n_fcnt = (app_sum > {1'b0, r_mint}) ? r_mint : app_sum[blpa_pkg::CNT_W-1:0];
        end

        // register write: rebuild the pool
        if (cfg_wr) begin
            n_init = pwdata[blpa_pkg::CNT_W-1:0];
            n_n    = cfg_n;
            n_clr  = '0;
            n_head = '{valid: 1'b1, idx: '0};
            n_tail = '{valid: 1'b1, idx: blpa_pkg::IDX_W'(cfg_n - 1'b1)};
            n_fcnt = cfg_n;
            n_mint = cfg_n;
        end
    end

    // control and pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= blpa_pkg::S_CLEAR;
            r_clr    <= '0;
            r_init   <= '0;
            r_n      <= RST_SIZE;
            r_head   <= '{valid: 1'b1, idx: '0};
            r_tail   <= '{valid: 1'b1, idx: blpa_pkg::IDX_W'(RST_SIZE - 1'b1)};
            r_fcnt   <= RST_SIZE;
            r_mint   <= RST_SIZE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_init   <= n_init;
            r_n      <= n_n;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fcnt   <= n_fcnt;
            r_mint   <= n_mint;
            r_ovalid <= n_ovalid;
        end
    end

    // per-command working registers and result payload
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_got    <= n_got;
        r_ch     <= n_ch;
        r_ct     <= n_ct;
        r_cur    <= n_cur;
        r_term   <= n_term;
        r_status <= n_status;
        r_chok   <= n_chok;
        r_ostat  <= n_ostat;
        r_ochok  <= n_ochok;
        r_ohead  <= n_ohead;
        r_otail  <= n_otail;
        r_otot   <= n_otot;
        r_ofree  <= n_ofree;
    end

    // next-pointer memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[r_cur.idx];
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_ostat;
    assign o_rsp.chain_head   = r_ohead;
    assign o_rsp.chain_tail   = r_otail;
    assign o_rsp.chain_valid  = r_ochok;
    assign o_rsp.pool_blocks  = r_otot;
    assign o_rsp.free_blocks  = r_ofree;

`ifndef SYNTH
    a_free_le_minted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_mint) else $error("free count above minted count");
    a_minted_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_mint) <= blpa_pkg::POOL_CAPACITY) else $error("minted past capacity");
    a_fail_no_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blpa_pkg::S_DONE && r_status) |-> !r_chok)
        else $error("failed alloc hands out a chain");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blpa_pkg::S_WALK_STEP) |-> (r_got != '0 && r_got <= r_cmd.cnt))
        else $error("walk count out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_b2f.pop |=> (r_state == blpa_pkg::S_EXEC))
        else $error("pop without dispatch");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for linked_block_pool_allocator_top: random and directed
// alloc/free/link requests against an in-bench pool predictor.
// Depends on blpa_pkg, blpa_if and the allocator RTL.
module tb;

    typedef struct packed {
        logic [1:0]     action;
        blpa_pkg::t_cnt cnt;
        blpa_pkg::t_idx fb;
        logic           fv;
        blpa_pkg::t_idx sb;
        logic           sv;
    } t_item;

    typedef struct packed {
        logic           status;
        blpa_pkg::t_idx head;
        blpa_pkg::t_idx tail;
        logic           cvalid;
        blpa_pkg::t_cnt total;
        blpa_pkg::t_cnt nfree;
    } t_res;

    typedef struct packed {
        blpa_pkg::t_idx head;
        blpa_pkg::t_idx tail;
        blpa_pkg::t_cnt cnt;
    } t_chain;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    blpa_req_if req();
    blpa_rsp_if rsp();

    linked_block_pool_allocator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted pool state
    blpa_pkg::t_ptr next_ptr [blpa_pkg::POOL_CAPACITY];
    blpa_pkg::t_ptr fl_head, fl_tail;
    int   free_cnt, minted_cnt;

    t_item  pend_items[$];
    t_res   expected_res[$];
    t_chain held_chains[$];
    blpa_pkg::t_cnt asked_cnt[$];

    int  n_err;
    int  n_mismatch;
    int  n_acc;
    int  n_res;
    int  n_fail_alloc;
    bit  burst;
    bit  held;
    int  hold_cnt;
    int  gap;
    int  stall;
    t_item cur;

    // rebuild the pool for a register value
    function automatic void pool_rebuild(int v);
        int n;
        n = (v == 0) ? blpa_pkg::INIT_DEFAULT
                     : ((v > blpa_pkg::INIT_LIMIT) ? blpa_pkg::INIT_LIMIT : v);
        for (int i = 0; i < blpa_pkg::POOL_CAPACITY; i++) begin
            next_ptr[i] = (i + 1 < n) ? blpa_pkg::t_ptr'{1'b1, blpa_pkg::t_idx'(i + 1)}
                                      : blpa_pkg::t_ptr'('0);
        end
        fl_head    = (n > 0) ? blpa_pkg::t_ptr'{1'b1, blpa_pkg::t_idx'(0)}
                             : blpa_pkg::t_ptr'('0);
        fl_tail    = (n > 0) ? blpa_pkg::t_ptr'{1'b1, blpa_pkg::t_idx'(n - 1)}
                             : blpa_pkg::t_ptr'('0);
        free_cnt   = n;
        minted_cnt = n;
    endfunction

    // append a chain to the free list, saturate the count
    function automatic void pool_append(blpa_pkg::t_ptr h, blpa_pkg::t_ptr t, int c);
        if (c == 0 || !h.valid || !t.valid) return;
        if (!fl_head.valid) fl_head = h;
        else if (fl_tail.valid) next_ptr[fl_tail.idx] = h;
        else fl_head = h;
        fl_tail = t;
        free_cnt += c;
        if (free_cnt > minted_cnt) free_cnt = minted_cnt;
    endfunction

    // compute the result of one request and advance the pool
    function automatic t_res pool_predict(t_item it);
        t_res r;
        blpa_pkg::t_ptr p1, p2, ch, ct, cur_p, b;
        int   k, got;
        bit   ok, broke;
        k  = it.cnt;
        p1 = it.fv ? blpa_pkg::t_ptr'{1'b1, it.fb} : blpa_pkg::t_ptr'('0);
        p2 = it.sv ? blpa_pkg::t_ptr'{1'b1, it.sb} : blpa_pkg::t_ptr'('0);
        ch = '0;
        ct = '0;
        ok = 0;
        r  = '0;
        if (it.action == blpa_pkg::ACT_ALLOC && k > 0) begin
            got = 0;
            if (free_cnt > 0) begin
                if (k >= free_cnt) begin
                    if (fl_head.valid && fl_tail.valid) begin
                        ch = fl_head;
                        ct = fl_tail;
                        got = free_cnt;
                    end
                    fl_head = '0;
                    fl_tail = '0;
                    free_cnt = 0;
                end else begin
                    cur_p = fl_head;
                    broke = 0;
                    while (got < k) begin
                        if (!cur_p.valid) begin
                            broke = 1;
                            break;
                        end
                        if (got == 0) ch = cur_p;
                        ct = cur_p;
                        got++;
                        cur_p = next_ptr[cur_p.idx];
                    end
                    if (broke) begin
                        fl_head = '0;
                        fl_tail = '0;
                        free_cnt = 0;
                    end else begin
                        fl_head = cur_p;
                        free_cnt -= got;
                    end
                    if (got > 0) next_ptr[ct.idx] = '0;
                end
            end
            // mint fresh blocks up to capacity
            while (got < k && minted_cnt < blpa_pkg::POOL_CAPACITY) begin
                b = blpa_pkg::t_ptr'{1'b1, blpa_pkg::t_idx'(minted_cnt)};
                next_ptr[minted_cnt] = '0;
                if (got == 0) ch = b;
                else next_ptr[ct.idx] = b;
                ct = b;
                minted_cnt++;
                got++;
            end
            if (got < k) begin
                pool_append(ch, ct, got);
                r.status = 1'b1;
            end else begin
                ok = 1;
            end
        end else if (it.action == blpa_pkg::ACT_FREE) begin
            pool_append(p1, p2, k);
        end else if (it.action == blpa_pkg::ACT_LINK) begin
            if (p1.valid) next_ptr[p1.idx] = p2;
        end
        if (ok) begin
            r.head = ch.idx;
            r.tail = ct.idx;
            r.cvalid = 1'b1;
        end
        r.total = blpa_pkg::t_cnt'(minted_cnt);
        r.nfree = blpa_pkg::t_cnt'(free_cnt);
        return r;
    endfunction

    function automatic t_item mk(logic [1:0] a, int k, int fb, bit fv, int sb, bit sv);
        t_item it;
        it.action = a;
        it.cnt = blpa_pkg::t_cnt'(k);
        it.fb = blpa_pkg::t_idx'(fb);
        it.fv = fv;
        it.sb = blpa_pkg::t_idx'(sb);
        it.sv = sv;
        return it;
    endfunction

    // one random request, mostly allocations and frees of chains handed out earlier
    function automatic t_item rand_item(bit allow_big);
        t_item it;
        t_chain c;
        logic [63:0] raw;
        int r, j;
        r = $urandom_range(0, 99);
        raw = {$urandom, $urandom};
        it = raw[$bits(t_item)-1:0];
        it.cnt = blpa_pkg::t_cnt'($urandom_range(0, 4096));
        if (r < 45) begin
            it.action = blpa_pkg::ACT_ALLOC;
            if (allow_big && $urandom_range(0, 199) == 0) begin
                it.cnt = blpa_pkg::t_cnt'(4096);
            end else if ($urandom_range(0, 19) == 0) begin
                it.cnt = blpa_pkg::t_cnt'($urandom_range(0, 64));
            end else begin
                it.cnt = blpa_pkg::t_cnt'($urandom_range(1, 8));
            end
        end else if (r < 75 && held_chains.size() > 0) begin
            j = $urandom_range(0, held_chains.size() - 1);
            c = held_chains[j];
            held_chains.delete(j);
            it = mk(blpa_pkg::ACT_FREE, c.cnt, c.head, 1, c.tail, 1);
        end else if (r < 85) begin
            it.action = blpa_pkg::ACT_LINK;
        end else if (r < 93) begin
            it.action = blpa_pkg::ACT_FREE;
            if ($urandom_range(0, 1)) it.cnt = blpa_pkg::t_cnt'($urandom_range(0, 3));
        end else begin
            it.action = blpa_pkg::ACT_UNUSED;
        end
        return it;
    endfunction

    // clock and reset; all inputs known from time zero
    initial begin
        i_clk = 0;
        i_rst_n = 0;
        req.valid = 0;
        req.action = '0;
        req.block_count = '0;
        req.first_block = '0;
        req.first_valid = 0;
        req.second_block = '0;
        req.second_valid = 0;
        rsp.ready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver: hold a beat until taken, then idle a drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 0;
            gap = 0;
        end else begin
            if (req.valid && req.ready) begin
                expected_res.push_back(pool_predict(cur));
                asked_cnt.push_back(cur.cnt);
                n_acc++;
            end
            if (!req.valid || req.ready) begin
                if (gap > 0) begin
                    gap--;
                    req.valid <= 0;
                end else if (pend_items.size() > 0) begin
                    cur = pend_items.pop_front();
                    req.action <= cur.action;
                    req.block_count <= cur.cnt;
                    req.first_block <= cur.fb;
                    req.first_valid <= cur.fv;
                    req.second_block <= cur.sb;
                    req.second_valid <= cur.sv;
                    req.valid <= 1;
                    gap = burst ? 0 : $urandom_range(0, 4);
                end else begin
                    req.valid <= 0;
                end
            end
        end
    end

    // long receiver hold-off once traffic is going
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
            held <= 0;
        end else if (n_acc >= 200 && !held) begin
            hold_cnt <= 400;
            held <= 1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // result monitor: compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        t_res got, exp_r;
        blpa_pkg::t_cnt k;
        if (!i_rst_n) begin
            rsp.ready <= 0;
            stall = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.status, rsp.chain_head, rsp.chain_tail, rsp.chain_valid,
                        rsp.pool_blocks, rsp.free_blocks};
                n_res++;
                if (expected_res.size() == 0) begin
                    n_err++;
                    if (n_mismatch++ < 10) $display("unexpected result beat %p", got);
                end else begin
                    exp_r = expected_res.pop_front();
                    k = asked_cnt.pop_front();
                    if (got !== exp_r) begin
                        n_err++;
                        if (n_mismatch++ < 10)
                            $display("mismatch at result %0d: expected %p, got %p",
                                     n_res, exp_r, got);
                    end
                    if (exp_r.status) n_fail_alloc++;
                    if (exp_r.cvalid) held_chains.push_back('{exp_r.head, exp_r.tail, k});
                end
                stall = burst ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) stall--;
            rsp.ready <= (hold_cnt == 0) && (stall == 0);
        end
    end

    // wait on settled values so a beat loaded at this edge is not missed
    task automatic wait_idle();
        while (pend_items.size() > 0 || req.valid || expected_res.size() > 0)
            @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // register write: setup then access cycle
    task automatic write_init_size(int v);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= '0;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        pool_rebuild(v);
        held_chains.delete();
    endtask

    task automatic feed(t_item it);
        while (pend_items.size() >= 4) @(posedge i_clk);
        pend_items.push_back(it);
    endtask

    initial begin
        int sizes [6];
        sizes = '{0, 1, 4096, 8191, 0, 5};
        n_err = 0;
        n_mismatch = 0;
        n_acc = 0;
        n_res = 0;
        n_fail_alloc = 0;
        burst = 0;
        pool_rebuild(0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: zero request, bad frees, links, odd action, exhaustion
        feed(mk(blpa_pkg::ACT_ALLOC, 0, 4095, 1, 4095, 1));
        feed(mk(blpa_pkg::ACT_ALLOC, 1, 0, 0, 0, 0));
        feed(mk(blpa_pkg::ACT_ALLOC, 3, 0, 0, 0, 0));
        feed(mk(blpa_pkg::ACT_FREE, 0, 0, 1, 0, 1));
        feed(mk(blpa_pkg::ACT_FREE, 1, 0, 0, 0, 1));
        feed(mk(blpa_pkg::ACT_FREE, 1, 0, 1, 0, 0));
        feed(mk(blpa_pkg::ACT_FREE, 1, 0, 1, 0, 1));
        feed(mk(blpa_pkg::ACT_LINK, 0, 5, 0, 9, 1));
        feed(mk(blpa_pkg::ACT_LINK, 0, 2, 1, 0, 0));
        feed(mk(blpa_pkg::ACT_LINK, 0, 1, 1, 2, 1));
        feed(mk(blpa_pkg::ACT_UNUSED, 4096, 4095, 1, 4095, 1));
        feed(mk(blpa_pkg::ACT_ALLOC, 2, 0, 0, 0, 0));
        feed(mk(blpa_pkg::ACT_ALLOC, 1019, 0, 0, 0, 0));
        feed(mk(blpa_pkg::ACT_ALLOC, 4096, 0, 0, 0, 0));
        feed(mk(blpa_pkg::ACT_ALLOC, 1, 0, 0, 0, 0));
        feed(mk(blpa_pkg::ACT_FREE, 4096, 10, 1, 4095, 1));
        feed(mk(blpa_pkg::ACT_LINK, 0, 4095, 1, 4095, 1));
        feed(mk(blpa_pkg::ACT_ALLOC, 4096, 0, 0, 0, 0));
        feed(mk(blpa_pkg::ACT_ALLOC, 5, 0, 0, 0, 0));

        // random phases over several pool sizes
        foreach (sizes[p]) begin
            if (p > 0) begin
                wait_idle();
                write_init_size(sizes[p]);
            end
            for (int i = 0; i < 265; i++) begin
                if (i % 60 == 0) burst = (i % 120 == 0);
                feed(rand_item(i % 90 == 7));
            end
        end
        burst = 0;
        wait_idle();

        $display("covered %0d requests over 6 pool sizes, %0d results, %0d failed allocs",
                 n_acc, n_res, n_fail_alloc);
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("timeout with %0d results outstanding", expected_res.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
